// ===== rtl/core/ising_lattice_metropolis_update_top_assert.svh =====
// Assertion macros shared by the lattice update RTL.
// Both sample on the rising edge of clock and are off while reset is high.
`ifndef ISING_LATTICE_METROPOLIS_UPDATE_TOP_ASSERT_SVH
`define ISING_LATTICE_METROPOLIS_UPDATE_TOP_ASSERT_SVH

// Same-cycle implication
`define ILMU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ILMU_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ilmu_pkg.sv =====
`timescale 1ns / 1ps

package ilmu_pkg;

   // Field widths
   localparam int OP_W        = 2;
   localparam int ROWCOL_W    = 6;
   localparam int RAND_W      = 16;
   localparam int THR_W       = 17;
   localparam int DE_W        = 5;
   localparam int ENERGY_W    = 15;
   localparam int MAGNET_W    = 14;
   localparam int CSR_INDEX_W = 1;
   localparam int SLOT_W      = 3;

   // Register reset values and indexes
   localparam logic [THR_W-1:0]       THR4_RESET = 17'd1200;
   localparam logic [THR_W-1:0]       THR8_RESET = 17'd22;
   localparam logic [CSR_INDEX_W-1:0] CSR_THR4   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THR8   = 1'b1;

   // Reported totals saturate to the field range
   localparam int ENERGY_MAX = 2 ** (ENERGY_W - 1) - 1;
   localparam int ENERGY_MIN = -(2 ** (ENERGY_W - 1));
   localparam int MAGNET_MAX = 2 ** (MAGNET_W - 1) - 1;
   localparam int MAGNET_MIN = -(2 ** (MAGNET_W - 1));

   // dE = 4*up_count - 8 for an up spin; the small positive step uses thr_4
   localparam int DE_BIAS     = 8;
   localparam int DE_MARGINAL = 4;

   // Read slots of a trial
   localparam logic [SLOT_W-1:0] SLOT_CENTER = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_UP     = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_DOWN   = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_LEFT   = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_RIGHT  = 3'd4;

   // Read slots of a recompute scan
   localparam logic [SLOT_W-1:0] SCAN_SITE = 3'd0;
   localparam logic [SLOT_W-1:0] SCAN_UP   = 3'd1;
   localparam logic [SLOT_W-1:0] SCAN_LEFT = 3'd2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_FILL  = 2'd1,
      OP_SCAN  = 2'd2,
      OP_TRIAL = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DONE,
      ST_TRIAL,
      ST_EVAL,
      ST_FILL,
      ST_SCAN,
      ST_SCAN_END
   } state_type;

endpackage

// ===== rtl/core/ilmu_if.sv =====
`timescale 1ns / 1ps

// Request channel: one op per transfer
interface ilmu_req_if import ilmu_pkg::*; ();
   logic                valid;
   logic                ready;
   op_type              op;
   logic [ROWCOL_W-1:0] row;
   logic [ROWCOL_W-1:0] col;
   logic                spin_up;
   logic [RAND_W-1:0]   rand_u;

   modport source (output valid, op, row, col, spin_up, rand_u, input ready);
   modport sink   (input valid, op, row, col, spin_up, rand_u, output ready);
endinterface

// Response channel: one result per op
interface ilmu_rsp_if import ilmu_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       accepted;
   logic signed [DE_W-1:0]     delta_energy;
   logic signed [ENERGY_W-1:0] energy;
   logic signed [MAGNET_W-1:0] magnetization;

   modport source (output valid, accepted, delta_energy, energy, magnetization, input ready);
   modport sink   (input valid, accepted, delta_energy, energy, magnetization, output ready);
endinterface

// ===== rtl/core/ising_lattice_metropolis_update_top.sv =====
// Channel   Dir  Carries
// req_ch    in   op, row, col, spin_up, rand_u
// rsp_ch    out  accepted, delta_energy, energy, magnetization
// csr_*     in   accept_thr_4 (index 0), accept_thr_8 (index 1)
//
// All lattice traffic goes through one single-port memory, one access per cycle:
// a trial is five reads plus a write-back on accept, recompute is three reads per site.
// Reset is synchronous; the lattice has no clearing pass.
// A finished result waits in the output register while the next op is taken;
// an op that finishes before that register frees waits in the done state.
`timescale 1ns / 1ps
`include "ising_lattice_metropolis_update_top_assert.svh"

module ising_lattice_metropolis_update_top
   import ilmu_pkg::*;
#(
   parameter int SIDE = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   ilmu_req_if.sink               req_ch,
   ilmu_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [THR_W-1:0]       csr_wdata
);

   localparam int CELLS = SIDE * SIDE;
   localparam int IW    = $clog2(SIDE);
   localparam int AW    = $clog2(CELLS);
   // Running totals are kept exactly; loads can push them past the lattice bound
   localparam int ET_W  = 32;
   localparam int MT_W  = 32;

   // Row or column modulo SIDE, restoring style over the input bits
   function automatic logic [IW-1:0] wrap_idx(logic [ROWCOL_W-1:0] v);
      int unsigned rem;
      rem = 32'(v);
      for (int i = ROWCOL_W - 1; i >= 0; i--) begin
         if (rem >= (SIDE << i)) begin
            rem = rem - (SIDE << i);
         end
      end
      return IW'(rem);
   endfunction

   function automatic logic [IW-1:0] next_idx(logic [IW-1:0] i);
      return (i == IW'(SIDE - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IW-1:0] prev_idx(logic [IW-1:0] i);
      return (i == '0) ? IW'(SIDE - 1) : i - 1'b1;
   endfunction

   function automatic logic [AW-1:0] site_addr(logic [IW-1:0] r, logic [IW-1:0] c);
      return AW'(r) * AW'(SIDE) + AW'(c);
   endfunction

   function automatic logic [ENERGY_W-1:0] sat_energy(logic [ET_W-1:0] v);
      logic signed [ET_W-1:0] sv;
      sv = $signed(v);
      if (int'(sv) > ENERGY_MAX) return ENERGY_W'(ENERGY_MAX);
      if (int'(sv) < ENERGY_MIN) return ENERGY_W'(ENERGY_MIN);
      return ENERGY_W'(sv);
   endfunction

   function automatic logic [MAGNET_W-1:0] sat_magnet(logic [MT_W-1:0] v);
      logic signed [MT_W-1:0] sv;
      sv = $signed(v);
      if (int'(sv) > MAGNET_MAX) return MAGNET_W'(MAGNET_MAX);
      if (int'(sv) < MAGNET_MIN) return MAGNET_W'(MAGNET_MIN);
      return MAGNET_W'(sv);
   endfunction

   state_type            state_ff, state_in;
   logic [IW-1:0]        row_ff, col_ff;
   logic                 spin_ff;
   logic [RAND_W-1:0]    rand_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic                 s_ff, up_ff;
   logic [2:0]           cnt_ff;
   logic [ET_W-1:0]      e_work_ff, e_work_in;
   logic [MT_W-1:0]      m_work_ff, m_work_in;
   logic [ET_W-1:0]      energy_ff;
   logic [MT_W-1:0]      magnet_ff;
   logic                 acc_ff;
   logic [DE_W-1:0]      de_ff;
   logic [THR_W-1:0]     thr4_ff, thr8_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_acc_ff;
   logic [DE_W-1:0]      rsp_de_ff;
   logic [ENERGY_W-1:0]  rsp_energy_ff;
   logic [MAGNET_W-1:0]  rsp_magnet_ff;
   logic                 rd_valid_ff;
   logic [SLOT_W-1:0]    rd_slot_ff;
   logic                 rdata_ff;

   logic                 lattice_mem [CELLS];
   logic                 mem_we, mem_re, mem_wdata;
   logic [AW-1:0]        mem_addr;

   logic                 out_free, accept_ok, req_xfer;
   logic [IW-1:0]        req_row, req_col;
   logic [IW-1:0]        row_up, row_dn, col_lf, col_rt;
   logic                 site_last;
   logic [2:0]           up_cnt;
   logic [DE_W-1:0]      de_pos, de_val;
   logic [THR_W-1:0]     thr_sel;
   logic                 acc_val;
   logic [1:0]           bond_cnt;
   logic [ET_W-1:0]      de_ext;
   logic [MT_W-1:0]      mag_step;

   // Handshake
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign accept_ok = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free);
   assign req_xfer  = req_ch.valid && accept_ok;
   assign req_ch.ready = accept_ok;

   // Site indexes and periodic neighbors
   assign req_row   = wrap_idx(req_ch.row);
   assign req_col   = wrap_idx(req_ch.col);
   assign row_up    = prev_idx(row_ff);
   assign row_dn    = next_idx(row_ff);
   assign col_lf    = prev_idx(col_ff);
   assign col_rt    = next_idx(col_ff);
   assign site_last = (row_ff == IW'(SIDE - 1)) && (col_ff == IW'(SIDE - 1));

   // Trial decision: last neighbor arrives in the eval cycle
   assign up_cnt  = cnt_ff + {2'b00, rdata_ff};
   assign de_pos  = DE_W'({up_cnt, 2'b00}) - DE_W'(DE_BIAS);
   assign de_val  = s_ff ? de_pos : DE_W'(0) - de_pos;
   assign thr_sel = (de_val == DE_W'(DE_MARGINAL)) ? thr4_ff : thr8_ff;
   assign acc_val = de_val[DE_W-1] || (de_val == '0) || (THR_W'(rand_ff) < thr_sel);
   assign de_ext  = {{(ET_W - DE_W){de_val[DE_W-1]}}, de_val};
   assign mag_step = s_ff ? {{(MT_W - 1){1'b1}}, 1'b0} : MT_W'(2);

   // Recompute: each unequal bond adds 1, each equal bond subtracts 1
   assign bond_cnt  = 2'(s_ff ^ up_ff) + 2'(s_ff ^ rdata_ff);
   assign e_work_in = e_work_ff + (ET_W'(bond_cnt) << 1) - ET_W'(2);
   assign m_work_in = m_work_ff + (s_ff ? MT_W'(1) : {MT_W{1'b1}});

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE, ST_DONE: begin
            if (req_xfer) begin
               unique case (req_ch.op)
                  OP_LOAD:  state_in = ST_DONE;
                  OP_FILL:  state_in = ST_FILL;
                  OP_SCAN:  state_in = ST_SCAN;
                  default:  state_in = ST_TRIAL;
               endcase
            end else if ((state_ff == ST_DONE) && out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_TRIAL:    if (slot_ff == SLOT_RIGHT) state_in = ST_EVAL;
         ST_EVAL:     state_in = ST_DONE;
         ST_FILL:     if (site_last) state_in = ST_DONE;
         ST_SCAN:     if (site_last && (slot_ff == SCAN_LEFT)) state_in = ST_SCAN_END;
         ST_SCAN_END: state_in = ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wdata = 1'b0;
      mem_addr  = site_addr(row_ff, col_ff);
      unique case (state_ff)
         ST_IDLE, ST_DONE: begin
            mem_addr = site_addr(req_row, req_col);
            if (req_xfer && (req_ch.op == OP_LOAD)) begin
               mem_we    = 1'b1;
               mem_wdata = req_ch.spin_up;
            end else if (req_xfer && (req_ch.op == OP_TRIAL)) begin
               mem_re = 1'b1;
            end
         end
         ST_TRIAL: begin
            mem_re = 1'b1;
            unique case (slot_ff)
               SLOT_UP:   mem_addr = site_addr(row_up, col_ff);
               SLOT_DOWN: mem_addr = site_addr(row_dn, col_ff);
               SLOT_LEFT: mem_addr = site_addr(row_ff, col_lf);
               default:   mem_addr = site_addr(row_ff, col_rt);
            endcase
         end
         ST_EVAL: begin
            mem_we    = acc_val;
            mem_wdata = !s_ff;
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = spin_ff;
         end
         ST_SCAN: begin
            mem_re = 1'b1;
            unique case (slot_ff)
               SCAN_UP:   mem_addr = site_addr(row_up, col_ff);
               SCAN_LEFT: mem_addr = site_addr(row_ff, col_lf);
               default:   mem_addr = site_addr(row_ff, col_ff);
            endcase
         end
         default: begin
         end
      endcase
   end

   // Lattice store, single port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         lattice_mem[mem_addr] <= mem_wdata;
      end else if (mem_re) begin
         rdata_ff <= lattice_mem[mem_addr];
      end
   end

   // Control registers and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         slot_ff      <= SLOT_CENTER;
         thr4_ff      <= THR4_RESET;
         thr8_ff      <= THR8_RESET;
         energy_ff    <= '0;
         magnet_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= mem_re;

         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // read slot sequencing
         if (req_xfer) begin
            slot_ff <= (req_ch.op == OP_TRIAL) ? SLOT_UP : SCAN_SITE;
         end else if (state_ff == ST_TRIAL) begin
            slot_ff <= slot_ff + 1'b1;
         end else if (state_ff == ST_SCAN) begin
            slot_ff <= (slot_ff == SCAN_LEFT) ? SCAN_SITE : slot_ff + 1'b1;
         end

         // configuration writes
         if (csr_we && (csr_index == CSR_THR4)) thr4_ff <= csr_wdata;
         if (csr_we && (csr_index == CSR_THR8)) thr8_ff <= csr_wdata;

         // totals
         if ((state_ff == ST_EVAL) && acc_val) begin
            energy_ff <= energy_ff + de_ext;
            magnet_ff <= magnet_ff + mag_step;
         end else if (state_ff == ST_SCAN_END) begin
            energy_ff <= e_work_in;
            magnet_ff <= m_work_in;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rd_slot_ff <= ((state_ff == ST_IDLE) || (state_ff == ST_DONE)) ? SLOT_CENTER : slot_ff;

      // op capture
      if (req_xfer) begin
         spin_ff   <= req_ch.spin_up;
         rand_ff   <= req_ch.rand_u;
         acc_ff    <= 1'b0;
         de_ff     <= '0;
         cnt_ff    <= '0;
         e_work_ff <= '0;
         m_work_ff <= '0;
      end

      // site pointer: fixed for load/trial, raster walk for fill/scan
      if (req_xfer) begin
         if ((req_ch.op == OP_FILL) || (req_ch.op == OP_SCAN)) begin
            row_ff <= '0;
            col_ff <= '0;
         end else begin
            row_ff <= req_row;
            col_ff <= req_col;
         end
      end else if ((state_ff == ST_FILL) ||
                   ((state_ff == ST_SCAN) && (slot_ff == SCAN_LEFT))) begin
         if (col_ff == IW'(SIDE - 1)) begin
            col_ff <= '0;
            row_ff <= next_idx(row_ff);
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end

      // trial read capture
      if ((state_ff == ST_TRIAL) && rd_valid_ff) begin
         if (rd_slot_ff == SLOT_CENTER) begin
            s_ff <= rdata_ff;
         end else begin
            cnt_ff <= up_cnt;
         end
      end

      // scan read capture and accumulation
      if ((state_ff == ST_SCAN) && rd_valid_ff) begin
         if (rd_slot_ff == SCAN_SITE) begin
            s_ff <= rdata_ff;
         end else if (rd_slot_ff == SCAN_UP) begin
            up_ff <= rdata_ff;
         end else begin
            e_work_ff <= e_work_in;
            m_work_ff <= m_work_in;
         end
      end

      if (state_ff == ST_EVAL) begin
         acc_ff <= acc_val;
         de_ff  <= de_val;
      end

      // output register load
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_acc_ff    <= acc_ff;
         rsp_de_ff     <= de_ff;
         rsp_energy_ff <= sat_energy(energy_ff);
         rsp_magnet_ff <= sat_magnet(magnet_ff);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.accepted      = rsp_acc_ff;
   assign rsp_ch.delta_energy  = $signed(rsp_de_ff);
   assign rsp_ch.energy        = $signed(rsp_energy_ff);
   assign rsp_ch.magnetization = $signed(rsp_magnet_ff);

   // Checks
   `ILMU_ASSERT_IMP(a_eval_sees_last_read, state_ff == ST_EVAL,
                    rd_valid_ff && (rd_slot_ff == SLOT_RIGHT),
                    "eval without last neighbor read")
   `ILMU_ASSERT_IMP(a_accept_when_quiet, req_xfer, !rd_valid_ff,
                    "op taken with a read in flight")
   `ILMU_ASSERT_IMP(a_port_single_access, mem_we, !mem_re,
                    "lattice read and write in one cycle")
   `ILMU_ASSERT_NXT(a_done_fills_output, (state_ff == ST_DONE) && out_free, rsp_valid_ff,
                    "done result not presented")
   `ILMU_ASSERT_IMP(a_totals_source, !$stable(energy_ff) || !$stable(magnet_ff),
                    ($past(state_ff) == ST_EVAL) || ($past(state_ff) == ST_SCAN_END),
                    "totals changed outside trial or recompute")

endmodule

// ===== tb/sv/ilmu_result_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, response and register ports of the lattice update block.
// Keeps its own copy of the lattice and the running totals, predicts one
// result per request transfer and compares every response transfer with it.
module ilmu_result_checker
   import ilmu_pkg::*;
#(
   parameter int SIDE = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   ilmu_req_if                    mon_req,
   ilmu_rsp_if                    mon_rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [THR_W-1:0]       csr_wdata,
   output int                     failures,
   output int                     pending
);

   typedef struct {
      logic                       accepted;
      logic signed [DE_W-1:0]     delta_energy;
      logic signed [ENERGY_W-1:0] energy;
      logic signed [MAGNET_W-1:0] magnetization;
   } site_report_type;

   // Shadow of the block: spins (1 = up), exact totals, thresholds
   bit              site_up [SIDE*SIDE];
   int              energy_sum;
   int              magnet_sum;
   int              thr_small_step;
   int              thr_large_step;
   site_report_type reports_due [$];

   function automatic int spin_of(int r, int c);
      return site_up[(r % SIDE) * SIDE + (c % SIDE)] ? 1 : -1;
   endfunction

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   task automatic note_failure(input string msg);
      if (failures < 20) begin
         $display("%0t ns  mismatch: %s", $time, msg);
      end
      failures++;
   endtask

   // Applies one op to the shadow lattice and returns the report it should give
   task automatic flip_or_update(input op_type op, input int r, input int c, input bit up,
                                 input int u, output site_report_type rep);
      int s;
      int nb;
      int de;
      int e;
      int m;
      bit acc;
      de  = 0;
      acc = 1'b0;
      case (op)
         OP_LOAD: begin
            site_up[r * SIDE + c] = up;
         end
         OP_FILL: begin
            foreach (site_up[k]) site_up[k] = up;
         end
         OP_SCAN: begin
            e = 0;
            m = 0;
            for (int i = 0; i < SIDE; i++) begin
               for (int j = 0; j < SIDE; j++) begin
                  s = spin_of(i, j);
                  e -= s * (spin_of(i + SIDE - 1, j) + spin_of(i, j + SIDE - 1));
                  m += s;
               end
            end
            energy_sum = e;
            magnet_sum = m;
         end
         default: begin
            s  = spin_of(r, c);
            nb = spin_of(r + 1, c) + spin_of(r + SIDE - 1, c)
               + spin_of(r, c + 1) + spin_of(r, c + SIDE - 1);
            de = 2 * s * nb;
            if (de <= 0) acc = 1'b1;
            else if (de == DE_MARGINAL) acc = (u < thr_small_step);
            else acc = (u < thr_large_step);
            if (acc) begin
               site_up[r * SIDE + c] = (s < 0);
               energy_sum += de;
               magnet_sum -= 2 * s;
            end
         end
      endcase
      rep.accepted      = acc;
      rep.delta_energy  = DE_W'(de);
      rep.energy        = ENERGY_W'(clamp(energy_sum, ENERGY_MIN, ENERGY_MAX));
      rep.magnetization = MAGNET_W'(clamp(magnet_sum, MAGNET_MIN, MAGNET_MAX));
   endtask

   always @(posedge clock) begin
      site_report_type rep;
      if (reset) begin
         energy_sum     = 0;
         magnet_sum     = 0;
         thr_small_step = int'(THR4_RESET);
         thr_large_step = int'(THR8_RESET);
         reports_due.delete();
         failures       = 0;
      end else begin
         // register writes
         if (csr_we) begin
            if (csr_index == CSR_THR4) thr_small_step = int'(csr_wdata);
            else if (csr_index == CSR_THR8) thr_large_step = int'(csr_wdata);
         end

         // response transfer against the oldest prediction
         if (mon_rsp.valid && mon_rsp.ready) begin
            if (reports_due.size() == 0) begin
               note_failure("response transfer with no request outstanding");
            end else begin
               rep = reports_due.pop_front();
               if (mon_rsp.accepted !== rep.accepted)
                  note_failure($sformatf("accepted got %0b want %0b",
                                         mon_rsp.accepted, rep.accepted));
               if (mon_rsp.delta_energy !== rep.delta_energy)
                  note_failure($sformatf("delta_energy got %0d want %0d",
                                         mon_rsp.delta_energy, rep.delta_energy));
               if (mon_rsp.energy !== rep.energy)
                  note_failure($sformatf("energy got %0d want %0d",
                                         mon_rsp.energy, rep.energy));
               if (mon_rsp.magnetization !== rep.magnetization)
                  note_failure($sformatf("magnetization got %0d want %0d",
                                         mon_rsp.magnetization, rep.magnetization));
            end
         end

         // request transfer: predict its report
         if (mon_req.valid && mon_req.ready) begin
            flip_or_update(mon_req.op, int'(mon_req.row), int'(mon_req.col),
                           mon_req.spin_up, int'(mon_req.rand_u), rep);
            reports_due.push_back(rep);
         end
      end
      pending = reports_due.size();
   end

endmodule

// ===== tb/sv/ising_lattice_metropolis_update_top_test.sv =====
`timescale 1ns / 1ps

// Drives ops into the lattice update block with bursty traffic and a stalling
// response side, walks several threshold settings and gives the verdict.
module ising_lattice_metropolis_update_top_test;
   import ilmu_pkg::*;

   localparam int SIDE       = 64;
   localparam int IDLE_LIMIT = 40000;
   localparam int PHASE_OPS  = 250;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [THR_W-1:0]       csr_wdata;

   ilmu_req_if req_ch ();
   ilmu_rsp_if rsp_ch ();

   int failures;
   int pending;
   int idle_cycles = 0;
   int stall_left  = 0;
   int calm_left   = 0;
   int burst_left;
   int cur_thr4;
   int cur_thr8;
   int settings_seen;
   int op_count [4];

   ising_lattice_metropolis_update_top #(.SIDE(SIDE)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ilmu_result_checker #(.SIDE(SIDE)) u_checker (
      .clock     (clock),
      .reset     (reset),
      .mon_req   (req_ch),
      .mon_rsp   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Response side: short stalls at random, with calm stretches of no stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (calm_left > 0) calm_left--;
         else if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
         if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 300);
      end
   end

   // Watchdog: no transfer on either channel for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ising_lattice_metropolis_update_top verification failed");
            $finish;
         end
      end
   end

   // One request transfer; valid stays high on return
   task automatic issue_op(input op_type op, input int r, input int c, input bit up,
                           input int u);
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.row     <= ROWCOL_W'(r);
      req_ch.col     <= ROWCOL_W'(c);
      req_ch.spin_up <= up;
      req_ch.rand_u  <= RAND_W'(u);
      do @(posedge clock); while (!req_ch.ready);
      op_count[op]++;
      @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding response
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Writes both thresholds; block must be idle
   task automatic write_thresholds(input int t4, input int t8);
      csr_we    <= 1'b1;
      csr_index <= CSR_THR4;
      csr_wdata <= THR_W'(t4);
      @(negedge clock);
      csr_index <= CSR_THR8;
      csr_wdata <= THR_W'(t8);
      @(negedge clock);
      csr_we    <= 1'b0;
      cur_thr4 = t4;
      cur_thr8 = t8;
      settings_seen++;
   endtask

   // rand_u next to a threshold, kept inside 16 bits
   function automatic int near_thr(input int t, input int offset);
      int v;
      v = t + offset;
      return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
   endfunction

   // Mostly trials, with loads to disorder the lattice, rare fills and recomputes
   task automatic random_op();
      int pick;
      int u;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
         0:       u = near_thr(cur_thr4, -1);
         1:       u = near_thr(cur_thr4, 0);
         2:       u = near_thr(cur_thr8, -1);
         3:       u = near_thr(cur_thr8, 0);
         4:       u = $urandom_range(0, 63);
         default: u = $urandom_range(0, 65535);
      endcase
      if (pick < 2)
         issue_op(OP_FILL, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 1), u);
      else if (pick < 4)
         issue_op(OP_SCAN, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 1), u);
      else if (pick < 20)
         issue_op(OP_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 1), u);
      else
         issue_op(OP_TRIAL, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 1), u);
   endtask

   // Bursty random phase
   task automatic random_phase(input int n_ops);
      int gap;
      bit bursty;
      bursty = 1'b1;
      for (int n = 0; n < n_ops; n++) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) bursty = !bursty;
            gap = bursty ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
         random_op();
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_THR4;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.op      = OP_LOAD;
      req_ch.row     = '0;
      req_ch.col     = '0;
      req_ch.spin_up = 1'b0;
      req_ch.rand_u  = '0;
      burst_left     = 0;
      cur_thr4       = int'(THR4_RESET);
      cur_thr8       = int'(THR8_RESET);
      settings_seen  = 1;
      foreach (op_count[k]) op_count[k] = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at reset thresholds; fill before any trial or scan so no unwritten site is read
      issue_op(OP_LOAD, 5, 5, 1'b1, 0);
      issue_op(OP_FILL, 0, 0, 1'b1, 0);
      issue_op(OP_SCAN, 0, 0, 1'b0, 0);
      issue_op(OP_TRIAL, 0, 0, 1'b0, 0);          // dE 8, below thr_8
      issue_op(OP_TRIAL, 0, 0, 1'b0, 65535);      // dE -8, flips back
      issue_op(OP_TRIAL, 63, 63, 1'b0, 65535);    // dE 8, rejected
      issue_op(OP_LOAD, 0, 63, 1'b0, 0);          // wrap neighbours of the corner
      issue_op(OP_LOAD, 63, 0, 1'b0, 0);
      issue_op(OP_TRIAL, 0, 0, 1'b0, 1199);       // dE 0
      issue_op(OP_TRIAL, 0, 0, 1'b0, 65535);      // dE 0 again
      issue_op(OP_LOAD, 1, 0, 1'b0, 0);
      issue_op(OP_TRIAL, 0, 0, 1'b0, 1199);       // dE -4
      issue_op(OP_TRIAL, 0, 0, 1'b0, 1199);       // dE 4, just below thr_4
      issue_op(OP_TRIAL, 0, 0, 1'b0, 0);          // dE -4
      issue_op(OP_TRIAL, 0, 0, 1'b0, 1200);       // dE 4, equal to thr_4
      issue_op(OP_SCAN, 0, 0, 1'b0, 0);
      issue_op(OP_FILL, 63, 63, 1'b0, 0);
      issue_op(OP_TRIAL, 31, 31, 1'b0, 21);       // dE 8, just below thr_8
      issue_op(OP_TRIAL, 32, 32, 1'b0, 22);       // dE 8, equal to thr_8
      issue_op(OP_SCAN, 0, 0, 1'b0, 0);
      settle();

      // Threshold of a full 1.0: everything accepted
      write_thresholds(65536, 65536);
      issue_op(OP_TRIAL, 40, 40, 1'b0, 65535);
      issue_op(OP_TRIAL, 40, 41, 1'b0, 65535);
      settle();

      // Zero threshold: no uphill flip
      write_thresholds(0, 0);
      issue_op(OP_TRIAL, 40, 42, 1'b0, 0);
      issue_op(OP_TRIAL, 10, 10, 1'b0, 0);
      settle();

      // Random phases over several threshold settings
      write_thresholds($urandom_range(0, 65536), $urandom_range(0, 65536));
      random_phase(PHASE_OPS);
      settle();
      write_thresholds(65536, 0);
      random_phase(PHASE_OPS);
      settle();
      write_thresholds(0, 65536);
      random_phase(PHASE_OPS);
      settle();
      write_thresholds(int'(THR4_RESET), int'(THR8_RESET));
      random_phase(PHASE_OPS);
      settle();
      write_thresholds($urandom_range(30000, 65536), $urandom_range(0, 30000));
      random_phase(PHASE_OPS);
      settle();

      repeat (20) @(negedge clock);
      $display("Covered %0d loads, %0d fills, %0d recomputes and %0d trials",
               op_count[OP_LOAD], op_count[OP_FILL], op_count[OP_SCAN], op_count[OP_TRIAL]);
      $display("over %0d threshold settings, with bursty requests and response stalls",
               settings_seen);
      if (failures == 0 && pending == 0) begin
         $display("ising_lattice_metropolis_update_top verification clean");
      end else begin
         $display("ising_lattice_metropolis_update_top verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ilmu_pkg.sv
rtl/core/ilmu_if.sv
rtl/core/ising_lattice_metropolis_update_top.sv
tb/sv/ilmu_result_checker.sv
tb/sv/ising_lattice_metropolis_update_top_test.sv
